[design/pdvm_pkg.sv]
// Package for the pressure dead-band valve map core.
// Holds field widths, fixed-point constants and configuration register indexes.
// No dependencies.
package pdvm_pkg;

  localparam int unsigned PressW = 23;
  localparam int unsigned ErrW   = 24;
  localparam int unsigned PosW   = 40;
  localparam int unsigned SpanW  = 38;
  localparam int unsigned OpenW  = 18;
  localparam int unsigned MagW   = 17;
  localparam int unsigned NumW   = 56;
  localparam int unsigned QBits  = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 19;

  localparam logic signed [PressW-1:0] PressLimit = 23'sd70000;
  localparam logic signed [OpenW-1:0]  QOne       = 18'sd32768;

  localparam logic [16:0] DeadZoneRst  = 17'd1000;
  localparam logic [17:0] PosLimitRst  = 18'd4000;
  localparam logic signed [18:0] NegLimitRst = -19'sd4000;
  localparam logic [15:0] GainRst      = 16'd256;
  localparam logic [15:0] OpenMinPosRst = 16'd6554;
  localparam logic [15:0] OpenMaxPosRst = 16'd17367;
  localparam logic signed [15:0] OpenMinNegRst = -16'sd31130;
  localparam logic signed [15:0] OpenMaxNegRst = -16'sd27853;

  typedef enum logic [CfgIdxW-1:0] {
    RegDeadZone   = 3'd0,
    RegPosLimit   = 3'd1,
    RegNegLimit   = 3'd2,
    RegGain       = 3'd3,
    RegOpenMinPos = 3'd4,
    RegOpenMaxPos = 3'd5,
    RegOpenMinNeg = 3'd6,
    RegOpenMaxNeg = 3'd7
  } cfg_reg_e;

endpackage

[design/pressure_deadband_valve_map_core.sv]
// Pressure dead-band valve map: clamp, error, segment select, linear map, duty split.
// Depends on pdvm_pkg.
// Accepts one request per cycle.
// Throughput is one item per cycle: the segment division is a 17-stage restoring divider,
// one quotient bit per stage. busy_o stays low; the receiver cannot stall results.
// Reset clears all valid bits and loads the register reset values; config changes take
// effect for requests started after the write.
module pressure_deadband_valve_map_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [pdvm_pkg::PressW-1:0]  target_pressure_i,
  input  logic signed [pdvm_pkg::PressW-1:0]  measured_pressure_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdvm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pdvm_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                valid_o,
  output logic signed [16:0]                  valve_opening_o,
  output logic [15:0]                         inflate_duty_o,
  output logic [15:0]                         deflate_duty_o
);

  localparam int unsigned PosW  = pdvm_pkg::PosW;
  localparam int unsigned SpanW = pdvm_pkg::SpanW;
  localparam int unsigned OpenW = pdvm_pkg::OpenW;
  localparam int unsigned MagW  = pdvm_pkg::MagW;
  localparam int unsigned NumW  = pdvm_pkg::NumW;
  localparam int unsigned QBits = pdvm_pkg::QBits;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  logic [16:0]        dead_zone_q;
  logic [17:0]        pos_limit_q;
  logic signed [18:0] neg_limit_q;
  logic [15:0]        gain_q;
  logic [15:0]        open_min_pos_q, open_max_pos_q;
  logic signed [15:0] open_min_neg_q, open_max_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q    <= pdvm_pkg::DeadZoneRst;
      pos_limit_q    <= pdvm_pkg::PosLimitRst;
      neg_limit_q    <= pdvm_pkg::NegLimitRst;
      gain_q         <= pdvm_pkg::GainRst;
      open_min_pos_q <= pdvm_pkg::OpenMinPosRst;
      open_max_pos_q <= pdvm_pkg::OpenMaxPosRst;
      open_min_neg_q <= pdvm_pkg::OpenMinNegRst;
      open_max_neg_q <= pdvm_pkg::OpenMaxNegRst;
    end else if (cfg_valid_i) begin
      unique case (pdvm_pkg::cfg_reg_e'(cfg_index_i))
        pdvm_pkg::RegDeadZone:   dead_zone_q    <= cfg_data_i[16:0];
        pdvm_pkg::RegPosLimit:   pos_limit_q    <= cfg_data_i[17:0];
        pdvm_pkg::RegNegLimit:   neg_limit_q    <= $signed(cfg_data_i[18:0]);
        pdvm_pkg::RegGain:       gain_q         <= cfg_data_i[15:0];
        pdvm_pkg::RegOpenMinPos: open_min_pos_q <= cfg_data_i[15:0];
        pdvm_pkg::RegOpenMaxPos: open_max_pos_q <= cfg_data_i[15:0];
        pdvm_pkg::RegOpenMinNeg: open_min_neg_q <= $signed(cfg_data_i[15:0]);
        pdvm_pkg::RegOpenMaxNeg: open_max_neg_q <= $signed(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // Breakpoints derived from the registers, at scale 512
  logic signed [PosW-1:0] pg_q, ng_q, pl_q, nl_q, nc_q;
  always_ff @(posedge clk_i) begin
    pg_q <= $signed({22'd0, pos_limit_q}) * $signed({24'd0, gain_q});
    ng_q <= PosW'(neg_limit_q) * $signed({24'd0, gain_q});
    pl_q <= pg_q <<< 1;
    nl_q <= ng_q <<< 1;
    nc_q <= (ng_q <<< 1) + ng_q;
  end

  logic signed [PosW-1:0] pc_w, dzs_w;
  assign pc_w  = $signed({22'd0, pos_limit_q}) * PosW'(768);
  assign dzs_w = $signed({23'd0, dead_zone_q}) <<< 9;

  // Stage 1: capture request
  logic                                 s1_vld_q;
  logic signed [pdvm_pkg::PressW-1:0]   s1_cmd_q, s1_meas_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= target_pressure_i;
    s1_meas_q <= measured_pressure_i;
  end

  // Stage 2: clamp command and form error
  logic signed [pdvm_pkg::PressW-1:0] cmd_clamp;
  logic signed [pdvm_pkg::ErrW-1:0]   err_d, err_q;
  logic                               s2_vld_q;
  always_comb begin
    priority if (s1_cmd_q > pdvm_pkg::PressLimit)  cmd_clamp = pdvm_pkg::PressLimit;
    else if (s1_cmd_q < -pdvm_pkg::PressLimit)     cmd_clamp = -pdvm_pkg::PressLimit;
    else                                            cmd_clamp = s1_cmd_q;
    err_d = pdvm_pkg::ErrW'(cmd_clamp) - pdvm_pkg::ErrW'(s1_meas_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end
  always_ff @(posedge clk_i) err_q <= err_d;

  // Stage 3: choose segment
  logic signed [PosW-1:0]  xs, err_w, dz_w;
  logic signed [PosW-1:0]  x_d, x1_d, x2_d, x_q, x1_q, x2_q;
  logic signed [OpenW-1:0] y1_d, y2_d, y1_q, y2_q;
  logic                    zero_d, zero_q, s3_vld_q;
  always_comb begin
    err_w  = PosW'(err_q);
    dz_w   = $signed({23'd0, dead_zone_q});
    xs     = err_w <<< 9;
    x_d    = xs;
    x1_d   = '0;
    x2_d   = '0;
    y1_d   = '0;
    y2_d   = '0;
    zero_d = 1'b0;
    priority if (err_w > dz_w) begin
      if (xs < pl_q) begin
        x1_d = dzs_w;
        x2_d = pl_q;
        y1_d = $signed({2'd0, open_min_pos_q});
        y2_d = $signed({2'd0, open_max_pos_q});
      end else begin
        x1_d = pl_q;
        x2_d = pc_w;
        y1_d = $signed({2'd0, open_max_pos_q});
        y2_d = pdvm_pkg::QOne;
      end
    end else if (err_w < -dz_w) begin
      if (xs > nl_q) begin
        x1_d = nl_q;
        x2_d = -dzs_w;
        y1_d = OpenW'(open_min_neg_q);
        y2_d = OpenW'(open_max_neg_q);
      end else begin
        x1_d = nc_q;
        x2_d = nl_q;
        y1_d = -pdvm_pkg::QOne;
        y2_d = OpenW'(open_min_neg_q);
      end
    end else begin
      zero_d = 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    y1_q   <= y1_d;
    y2_q   <= y2_d;
    zero_q <= zero_d;
  end

  // Stage 4: clamp into segment; degenerate cases become a zero-slope map
  logic signed [PosW-1:0]  span_s, xc;
  logic signed [OpenW-1:0] dy_s;
  logic [SpanW-1:0]        dx_d, span_d, dx_q, span_q;
  logic [MagW-1:0]         dmag_d, dmag_q;
  logic                    dneg_d, dneg_q, s4_vld_q;
  logic signed [OpenW-1:0] base_d, base_q;
  always_comb begin
    span_s = x2_q - x1_q;
    dy_s   = y2_q - y1_q;
    xc     = x_q;
    dx_d   = '0;
    span_d = SpanW'(1);
    dmag_d = '0;
    dneg_d = 1'b0;
    base_d = y1_q;
    priority if (zero_q) begin
      base_d = '0;
    end else if (span_s <= 0) begin
      base_d = (x_q >= x2_q) ? y2_q : y1_q;
    end else begin
      if (xc < x1_q) xc = x1_q;
      if (xc > x2_q) xc = x2_q;
      dx_d   = SpanW'(xc - x1_q);
      span_d = SpanW'(span_s);
      dneg_d = dy_s[OpenW-1];
      dmag_d = dy_s[OpenW-1] ? MagW'(-dy_s) : MagW'(dy_s);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else         s4_vld_q <= s3_vld_q;
  end
  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    span_q <= span_d;
    dmag_q <= dmag_d;
    dneg_q <= dneg_d;
    base_q <= base_d;
  end

  // Stage 5: numerator product
  logic [NumW-1:0]         num_q;
  logic [SpanW-1:0]        s5_span_q;
  logic                    s5_neg_q, s5_vld_q;
  logic signed [OpenW-1:0] s5_base_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else         s5_vld_q <= s4_vld_q;
  end
  always_ff @(posedge clk_i) begin
    num_q     <= NumW'(dx_q) * NumW'(dmag_q);
    s5_span_q <= span_q;
    s5_neg_q  <= dneg_q;
    s5_base_q <= base_q;
  end

  // Divider: one quotient bit per stage, most significant first
  logic [NumW-1:0]         dv_rem_q  [QBits+1];
  logic [QBits-1:0]        dv_quo_q  [QBits+1];
  logic [SpanW-1:0]        dv_span_q [QBits+1];
  logic                    dv_neg_q  [QBits+1];
  logic                    dv_vld_q  [QBits+1];
  logic signed [OpenW-1:0] dv_base_q [QBits+1];

  assign dv_rem_q[0]  = num_q;
  assign dv_quo_q[0]  = '0;
  assign dv_span_q[0] = s5_span_q;
  assign dv_neg_q[0]  = s5_neg_q;
  assign dv_vld_q[0]  = s5_vld_q;
  assign dv_base_q[0] = s5_base_q;

  for (genvar k = 0; k < QBits; k++) begin : g_div
    localparam int unsigned Sh = QBits - 1 - k;
    logic [NumW-1:0]  trial;
    logic             take;
    logic [QBits-1:0] quo_d;
    always_comb begin
      trial = NumW'(dv_span_q[k]) << Sh;
      take  = dv_rem_q[k] >= trial;
      quo_d = dv_quo_q[k];
      quo_d[Sh] = take;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[k+1] <= 1'b0;
      else         dv_vld_q[k+1] <= dv_vld_q[k];
    end
    always_ff @(posedge clk_i) begin
      dv_rem_q[k+1]  <= take ? dv_rem_q[k] - trial : dv_rem_q[k];
      dv_quo_q[k+1]  <= quo_d;
      dv_span_q[k+1] <= dv_span_q[k];
      dv_neg_q[k+1]  <= dv_neg_q[k];
      dv_base_q[k+1] <= dv_base_q[k];
    end
  end

  // Output stage: apply sign, add base, clamp, split duties
  logic signed [OpenW+1:0] qs, op_sum, op_c;
  logic signed [16:0]      open_d;
  always_comb begin
    qs     = $signed({3'd0, dv_quo_q[QBits]});
    if (dv_neg_q[QBits]) qs = -qs;
    op_sum = (OpenW+2)'(dv_base_q[QBits]) + qs;
    priority if (op_sum > (OpenW+2)'(pdvm_pkg::QOne))       op_c = (OpenW+2)'(pdvm_pkg::QOne);
    else if (op_sum < -((OpenW+2)'(pdvm_pkg::QOne)))        op_c = -((OpenW+2)'(pdvm_pkg::QOne));
    else                                                     op_c = op_sum;
    open_d = op_c[16:0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else         valid_o <= dv_vld_q[QBits];
  end
  always_ff @(posedge clk_i) begin
    valve_opening_o <= open_d;
    inflate_duty_o  <= (op_c > 0) ? op_c[15:0] : 16'd0;
    deflate_duty_o  <= (op_c < 0) ? 16'((-op_c)) : 16'd0;
  end

endmodule
